// ===== src/spq_pkg.sv =====
`timescale 1ns / 1ps
// spq_pkg: shared types and constants for the sorted priority queue.
// No dependencies.

package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 8;

    localparam logic [1:0] REQ_ENQ  = 2'd0;
    localparam logic [1:0] REQ_DEQ  = 2'd1;
    localparam logic [1:0] REQ_PEEK = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]  prio;
    } entry_t;

    typedef struct packed {
        logic   enq;
        logic   deq;
        entry_t item;
    } cell_cmd_t;

endpackage

// ===== src/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// sorted_priority_queue: top level, a row of spq_cell slots kept sorted by
// priority plus the fill count and result register. Depends on spq_pkg, spq_cell.
//
// Usage:
//   Requests arrive on s_t*: s_tuser carries the request kind (enqueue,
//   dequeue head, peek head), s_tdata the value and priority for enqueue.
//   Every request gives exactly one result on m_t*: m_tuser holds the status
//   (ok, full, empty), m_tdata the head value on a good peek and the empty
//   and full flags after the request.
//   Slot 0 is always the head; smaller priority numbers come first and equal
//   priorities leave in arrival order.
//   The result is registered and appears in the cycle after accept.
//   Throughput: one request per cycle while the receiver takes results; each
//   accepted request shifts the whole row at once, and the fill count is updated alongside.
//   When the receiver stalls, the result holds in the output register and
//   s_tready drops until it is taken.
//   Reset (aresetn low, synchronous) empties the queue and drops m_tvalid;
//   slot contents are not cleared, only the fill count.

module sorted_priority_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // [31:0] item_value, [39:32] item_priority
    input  logic [1:0]  s_tuser,  // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // [31:0] head_value, [32] is_empty, [33] is_full, zero pad
    output logic [1:0]  m_tuser   // [1:0] status
);

    localparam int N = spq_pkg::CAPACITY;

    logic [spq_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                        m_valid_reg, m_valid_next;
    logic [1:0]                  status_reg, status_next;
    logic [spq_pkg::VALUE_W-1:0] head_reg, head_next;
    logic                        empty_reg, empty_next;
    logic                        full_reg, full_next;

    logic               accept;
    logic               is_empty_now, is_full_now;
    spq_pkg::cell_cmd_t cmd;
    spq_pkg::entry_t    cell_entry [N];
    logic               cell_keep  [N];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign is_empty_now = (count_reg == '0);
    assign is_full_now  = (count_reg >= spq_pkg::COUNT_W'(N));

    assign cmd.enq        = accept && (s_tuser == spq_pkg::REQ_ENQ) && !is_full_now;
    assign cmd.deq        = accept && (s_tuser == spq_pkg::REQ_DEQ) && !is_empty_now;
    assign cmd.item.value = s_tdata[31:0];
    assign cmd.item.prio  = s_tdata[39:32];

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            logic            lk;
            spq_pkg::entry_t le;
            spq_pkg::entry_t re;
            if (g == 0) begin : g_first
                assign lk = 1'b1;
                assign le = '0;
            end else begin : g_mid
                assign lk = cell_keep[g-1];
                assign le = cell_entry[g-1];
            end
            if (g == N - 1) begin : g_last
                assign re = '0;
            end else begin : g_inner
                assign re = cell_entry[g+1];
            end
            spq_cell u_cell (
                .aclk        (aclk),
                .cmd         (cmd),
                .occupied    (spq_pkg::COUNT_W'(g) < count_reg),
                .left_keep   (lk),
                .left_entry  (le),
                .right_entry (re),
                .keep        (cell_keep[g]),
                .entry       (cell_entry[g])
            );
        end
    endgenerate

    always_comb begin
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        head_next    = head_reg;
        empty_next   = empty_reg;
        full_next    = full_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next = 1'b1;
            status_next  = spq_pkg::ST_OK;
            head_next    = '0;
            case (s_tuser)
                spq_pkg::REQ_ENQ: begin
                    if (is_full_now) begin
                        status_next = spq_pkg::ST_FULL;
                    end
                end
                spq_pkg::REQ_DEQ: begin
                    if (is_empty_now) begin
                        status_next = spq_pkg::ST_EMPTY;
                    end
                end
                spq_pkg::REQ_PEEK: begin
                    if (is_empty_now) begin
                        status_next = spq_pkg::ST_EMPTY;
                    end else begin
                        head_next = cell_entry[0].value;
                    end
                end
                default: begin
                end
            endcase
            if (cmd.enq) begin
                count_next = count_reg + 1'b1;
            end else if (cmd.deq) begin
                count_next = count_reg - 1'b1;
            end
            empty_next = (count_next == '0);
            full_next  = (count_next >= spq_pkg::COUNT_W'(N));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        status_reg <= status_next;
        head_reg   <= head_next;
        empty_reg  <= empty_next;
        full_reg   <= full_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {6'd0, full_reg, empty_reg, head_reg};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= spq_pkg::COUNT_W'(N))
        else $error("fill count above capacity");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted request produced no result");

    a_full_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == spq_pkg::REQ_ENQ && is_full_now)
            |=> (m_tuser == spq_pkg::ST_FULL) && $stable(count_reg))
        else $error("enqueue on full queue not rejected");

    a_deq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.deq |=> count_reg == $past(count_reg) - 1'b1)
        else $error("dequeue did not lower fill count");
`endif

endmodule

// ===== src/spq_cell.sv =====
`timescale 1ns / 1ps
// spq_cell: one slot of the sorted cell row; holds an entry and shifts it
// toward either neighbor. Depends on spq_pkg.

module spq_cell (
    input  logic               aclk,
    input  spq_pkg::cell_cmd_t cmd,
    input  logic               occupied,
    input  logic               left_keep,
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    output logic               keep,
    output spq_pkg::entry_t    entry
);

    spq_pkg::entry_t entry_reg;
    spq_pkg::entry_t entry_next;

    // entries with priority <= the new one stay put
    assign keep  = occupied && (entry_reg.prio <= cmd.item.prio);
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (cmd.enq) begin
            if (!keep) begin
                entry_next = left_keep ? cmd.item : left_entry;
            end
        end else if (cmd.deq) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

// ===== tb/sorted_priority_queue_tb.sv =====
`timescale 1ns / 1ps
// sorted_priority_queue_tb: self-checking stream testbench for the sorted priority queue.
// Predicts each result from a local copy of the sorted store. Depends on spq_pkg and
// sorted_priority_queue.

module sorted_priority_queue_tb;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_REQS = 1850;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_LEN    = 80;
    localparam int CALM_TAIL   = 200;
    localparam int IDLE_LIMIT  = 2000;

    typedef struct {
        logic [1:0]                  kind;
        logic [spq_pkg::VALUE_W-1:0] value;
        logic [spq_pkg::PRIO_W-1:0]  prio;
        bit                          wait_drained;
    } spq_req_t;

    typedef struct {
        logic [1:0]                  status;
        logic [spq_pkg::VALUE_W-1:0] head;
        logic                        empty;
        logic                        full;
    } spq_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;  // [31:0] item_value, [39:32] item_priority
    logic [1:0]  s_tuser  = '0;  // [1:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // [31:0] head_value, [32] is_empty, [33] is_full, zero pad
    logic [1:0]  m_tuser;        // [1:0] status

    sorted_priority_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    spq_req_t    req_q[$];
    spq_result_t expected_results[$];
    spq_req_t    cur_req;

    logic [spq_pkg::VALUE_W-1:0] store_value[spq_pkg::CAPACITY];
    logic [spq_pkg::PRIO_W-1:0]  store_prio[spq_pkg::CAPACITY];
    int                          store_count = 0;

    int   total_reqs    = 0;
    int   accepted_reqs = 0;
    int   fail_count    = 0;
    int   s_gap         = 0;
    int   m_gap         = 0;
    int   hold_left     = 0;
    bit   hold_done     = 0;
    int   idle_cycles   = 0;
    logic calm;

    assign calm = (accepted_reqs + CALM_TAIL >= total_reqs);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic spq_result_t queue_step(spq_req_t r);
        spq_result_t res;
        int pos;
        int i;
        res.status = spq_pkg::ST_OK;
        res.head   = '0;
        case (r.kind)
            spq_pkg::REQ_ENQ: begin
                if (store_count >= spq_pkg::CAPACITY) begin
                    res.status = spq_pkg::ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < store_count && store_prio[pos] <= r.prio)
                        pos++;
                    for (i = store_count; i > pos; i--) begin
                        store_value[i] = store_value[i-1];
                        store_prio[i]  = store_prio[i-1];
                    end
                    store_value[pos] = r.value;
                    store_prio[pos]  = r.prio;
                    store_count++;
                end
            end
            spq_pkg::REQ_DEQ: begin
                if (store_count == 0) begin
                    res.status = spq_pkg::ST_EMPTY;
                end else begin
                    for (i = 0; i + 1 < store_count; i++) begin
                        store_value[i] = store_value[i+1];
                        store_prio[i]  = store_prio[i+1];
                    end
                    store_count--;
                end
            end
            spq_pkg::REQ_PEEK: begin
                if (store_count == 0)
                    res.status = spq_pkg::ST_EMPTY;
                else
                    res.head = store_value[0];
            end
            default: ;
        endcase
        res.empty = (store_count == 0);
        res.full  = (store_count >= spq_pkg::CAPACITY);
        return res;
    endfunction

    task automatic add_req(logic [1:0] kind, logic [spq_pkg::VALUE_W-1:0] value,
                           logic [spq_pkg::PRIO_W-1:0] prio);
        spq_req_t r;
        r.kind         = kind;
        r.value        = value;
        r.prio         = prio;
        r.wait_drained = 0;
        req_q.push_back(r);
    endtask

    task automatic build_requests();
        int counted;
        int mode;
        int len;
        int pick;
        int drain_mark;
        logic [1:0]                  kind;
        logic [spq_pkg::VALUE_W-1:0] value;
        logic [spq_pkg::PRIO_W-1:0]  prio;
        // empty queue, then extremes and a tie on priority
        add_req(spq_pkg::REQ_PEEK, '0, '0);
        add_req(spq_pkg::REQ_DEQ, '0, '0);
        add_req(REQ_UNUSED, 32'hFFFF_FFFF, 8'hFF);
        add_req(spq_pkg::REQ_ENQ, 32'hFFFF_FFFF, 8'hFF);
        add_req(spq_pkg::REQ_ENQ, 32'h0000_0000, 8'h00);
        add_req(spq_pkg::REQ_ENQ, 32'hA5A5_A5A5, 8'h00);
        add_req(spq_pkg::REQ_PEEK, '0, '0);
        add_req(spq_pkg::REQ_DEQ, '0, '0);
        add_req(spq_pkg::REQ_PEEK, '0, '0);
        // fill up, then enqueue into a full queue
        for (int i = 0; i < 14; i++)
            add_req(spq_pkg::REQ_ENQ, $urandom,
                    (i % 3 == 0) ? 8'd100 : 8'($urandom_range(0, 255)));
        add_req(spq_pkg::REQ_ENQ, 32'h5A5A_5A5A, 8'h00);
        add_req(REQ_UNUSED, '0, '0);

        drain_mark = req_q.size();
        counted = 0;
        while (counted < RANDOM_REQS) begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(4, 40);
            repeat (len) begin
                pick = $urandom_range(0, 99);
                case (mode)
                    0: kind = (pick < 80) ? spq_pkg::REQ_ENQ :
                              (pick < 90) ? spq_pkg::REQ_DEQ : spq_pkg::REQ_PEEK;
                    1: kind = (pick < 15) ? spq_pkg::REQ_ENQ :
                              (pick < 75) ? spq_pkg::REQ_DEQ : spq_pkg::REQ_PEEK;
                    default: kind = (pick < 40) ? spq_pkg::REQ_ENQ :
                                    (pick < 75) ? spq_pkg::REQ_DEQ : spq_pkg::REQ_PEEK;
                endcase
                if ($urandom_range(0, 49) == 0)
                    kind = REQ_UNUSED;
                pick = $urandom_range(0, 19);
                value = (pick == 0) ? '0 : (pick == 1) ? '1 : spq_pkg::VALUE_W'($urandom);
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    prio = '0;
                else if (pick == 1)
                    prio = '1;
                else if (pick < 10)
                    prio = spq_pkg::PRIO_W'($urandom_range(0, 7));
                else
                    prio = spq_pkg::PRIO_W'($urandom_range(0, 255));
                add_req(kind, value, prio);
                if (kind != REQ_UNUSED)
                    counted++;
            end
        end
        req_q[drain_mark].wait_drained = 1;
        req_q[drain_mark + 900].wait_drained = 1;
        total_reqs = req_q.size();
    endtask

    task automatic check_field(string fname, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", fname, exp_v, act_v);
            fail_count++;
        end
    endtask

    // request driver
    always @(posedge aclk) begin
        logic fire;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            fire = s_tvalid && s_tready;
            if (fire) begin
                expected_results.push_back(queue_step(cur_req));
                accepted_reqs <= accepted_reqs + 1;
            end
            if (fire || !s_tvalid) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_tvalid <= 1'b0;
                end else if (req_q.size() == 0 ||
                             (req_q[0].wait_drained && expected_results.size() != 0)) begin
                    s_tvalid <= 1'b0;
                end else if (!calm && $urandom_range(0, 7) == 0) begin
                    s_gap = $urandom_range(0, 2);
                    s_tvalid <= 1'b0;
                end else begin
                    cur_req = req_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {cur_req.prio, cur_req.value};
                    s_tuser  <= cur_req.kind;
                end
            end
        end
    end

    // result receiver, with one long hold-off to back up the input
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (!hold_done && accepted_reqs >= HOLD_AT) begin
                hold_done = 1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (m_gap > 0) begin
                m_gap--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_gap = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        spq_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result with no request pending: status %0d", m_tuser);
                fail_count++;
            end else begin
                exp_r = expected_results.pop_front();
                check_field("status", 32'(exp_r.status), 32'(m_tuser));
                check_field("head_value", exp_r.head, m_tdata[31:0]);
                check_field("is_empty", 32'(exp_r.empty), 32'(m_tdata[32]));
                check_field("is_full", 32'(exp_r.full), 32'(m_tdata[33]));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("sorted_priority_queue regression: fail");
            $finish;
        end
    end

    initial begin
        build_requests();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        while (req_q.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("sorted_priority_queue regression: pass");
        else
            $display("sorted_priority_queue regression: fail");
        $finish;
    end

endmodule
